@@ hw/rtl/quadrature_position_speed_unit_macros.svh @@
// Assertion macros shared by the quadrature position/speed unit.
// Assumes clk_i and rst_ni are visible in the module that uses them.
`ifndef QUADRATURE_POSITION_SPEED_UNIT_MACROS_SVH
`define QUADRATURE_POSITION_SPEED_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QPSU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define QPSU_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define QPSU_ASSERT(name, prop, msg)
`define QPSU_NEVER(name, expr, msg)
`endif
`endif

@@ hw/rtl/qps_pkg.sv @@
// Shared types, constants and the quadrature step table.
// No dependencies.
package qps_pkg;

  localparam int unsigned DATA_BITS  = 32;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned STEP_BITS  = $clog2(DATA_BITS);

  localparam logic [DATA_BITS-1:0] TIMEOUT_RESET = DATA_BITS'(100000);
  localparam logic [DATA_BITS-1:0] POS_MAX       = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic [DATA_BITS-1:0] NEG_MAX       = {1'b1, {(DATA_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SPEED_SCALE  = 2'd0,
    REG_STALE_LIMIT  = 2'd1,
    REG_PRESET_COUNT = 2'd2
  } cfg_reg_e;

  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_FWD  = 2'b01;
  localparam logic [1:0] STEP_REV  = 2'b11;

  // index {prev_b, prev_a, cur_b, cur_a}
  localparam logic [1:0] QUAD_TABLE [16] = '{
    STEP_NONE, STEP_FWD,  STEP_REV,  STEP_NONE,
    STEP_REV,  STEP_NONE, STEP_NONE, STEP_FWD,
    STEP_FWD,  STEP_NONE, STEP_NONE, STEP_REV,
    STEP_NONE, STEP_REV,  STEP_FWD,  STEP_NONE
  };

  typedef struct packed {
    logic load_item;
    logic update;
    logic div_start;
    logic clear_speed;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic speed_needed;
    logic div_busy;
    logic div_done;
  } dp_status_t;

endpackage

@@ hw/rtl/qps_if.sv @@
// Request channel interfaces: input items, results and register writes.
// Depends on qps_pkg.
interface qps_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic                          level_a;
  logic                          level_b;
  logic [qps_pkg::TIME_BITS-1:0] now_time;

  modport source (output valid, cmd, level_a, level_b, now_time, input ready);
  modport sink   (input valid, cmd, level_a, level_b, now_time, output ready);
endinterface

interface qps_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qps_pkg::DATA_BITS-1:0] position;
  logic signed [1:0]                    direction;
  logic        [qps_pkg::DATA_BITS-1:0] edge_interval;
  logic signed [qps_pkg::DATA_BITS-1:0] speed;

  modport source (output valid, position, direction, edge_interval, speed, input ready);
  modport sink   (input valid, position, direction, edge_interval, speed, output ready);
endinterface

interface qps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    index;
  logic [qps_pkg::DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/qps_div.sv @@
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on qps_pkg.
module qps_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [qps_pkg::DATA_BITS-1:0] dividend_i,
  input  logic [qps_pkg::DATA_BITS-1:0] divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [qps_pkg::DATA_BITS-1:0] quotient_o
);

  localparam int unsigned W = qps_pkg::DATA_BITS;

  logic                               busy_q, done_q;
  logic [qps_pkg::STEP_BITS-1:0]      cnt_q;
  logic [W-1:0]                       quo_q, rem_q, dsr_q;
  logic [W:0]                         rem_sh;
  logic [W+1:0]                       diff;

  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == qps_pkg::STEP_BITS'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], ~diff[W+1]};
      rem_q <= diff[W+1] ? rem_sh[W-1:0] : diff[W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hw/rtl/qps_datapath.sv @@
// Datapath: config registers, count/time state, speed saturation and result register.
// Depends on qps_pkg and qps_div.
module qps_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  qps_pkg::dp_cmd_t                     cmd_i,
  output qps_pkg::dp_status_t                  status_o,
  input  logic [1:0]                           in_cmd_i,
  input  logic                                 in_level_a_i,
  input  logic                                 in_level_b_i,
  input  logic [qps_pkg::TIME_BITS-1:0]        in_now_time_i,
  input  logic                                 cfg_write_i,
  input  logic [1:0]                           cfg_index_i,
  input  logic [qps_pkg::DATA_BITS-1:0]        cfg_data_i,
  output logic signed [qps_pkg::DATA_BITS-1:0] position_o,
  output logic signed [1:0]                    direction_o,
  output logic [qps_pkg::DATA_BITS-1:0]        edge_interval_o,
  output logic signed [qps_pkg::DATA_BITS-1:0] speed_o
);

  localparam int unsigned W  = qps_pkg::DATA_BITS;
  localparam int unsigned CW = qps_pkg::COUNT_BITS;
  localparam int unsigned TW = qps_pkg::TIME_BITS;

  logic [W-1:0]  speed_scale_q, timeout_q, preset_q;
  logic [1:0]    item_cmd_q, item_pins_q;
  logic [TW-1:0] item_now_q;
  logic [1:0]    prev_pins_q, dir_q;
  logic [CW-1:0] count_q;
  logic [TW-1:0] last_time_q, interval_q;
  logic [W-1:0]  speed_q;
  logic          live_q;
  logic [TW-1:0] elapsed;
  logic [1:0]    step;
  logic [W-1:0]  quotient, speed_sat;
  logic          div_busy, div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_scale_q <= '0;
      timeout_q     <= qps_pkg::TIMEOUT_RESET;
      preset_q      <= '0;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        qps_pkg::REG_SPEED_SCALE:  speed_scale_q <= cfg_data_i;
        qps_pkg::REG_STALE_LIMIT:  timeout_q     <= cfg_data_i;
        qps_pkg::REG_PRESET_COUNT: preset_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_cmd_q  <= in_cmd_i;
      item_pins_q <= {in_level_b_i, in_level_a_i};
      item_now_q  <= in_now_time_i;
    end
  end

  assign elapsed = item_now_q - last_time_q;
  assign step    = qps_pkg::QUAD_TABLE[{prev_pins_q, item_pins_q}];

  always_comb begin
    if (dir_q == qps_pkg::STEP_FWD) begin
      speed_sat = (quotient > qps_pkg::POS_MAX) ? qps_pkg::POS_MAX : quotient;
    end else begin
      speed_sat = (quotient > qps_pkg::NEG_MAX) ? qps_pkg::NEG_MAX : W'(0) - quotient;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pins_q <= '0;
      dir_q       <= qps_pkg::STEP_NONE;
      count_q     <= '0;
      last_time_q <= '0;
      interval_q  <= '0;
      speed_q     <= '0;
      live_q      <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        if (item_cmd_q == qps_pkg::CMD_EDGE) begin
          dir_q       <= step;
          prev_pins_q <= item_pins_q;
          interval_q  <= elapsed;
          last_time_q <= item_now_q;
          count_q     <= count_q + {{(CW-2){step[1]}}, step};
          live_q      <= 1'b1;
        end else begin
          if (item_cmd_q == qps_pkg::CMD_LOAD) begin
            count_q <= CW'(preset_q);
          end
          live_q <= (W'(elapsed) < timeout_q);
        end
      end
      if (cmd_i.clear_speed) begin
        speed_q <= '0;
      end else if (div_done) begin
        speed_q <= speed_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      position_o      <= W'(signed'(count_q));
      direction_o     <= dir_q;
      edge_interval_o <= W'(interval_q);
      speed_o         <= speed_q;
    end
  end

  qps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (speed_scale_q),
    .divisor_i  (W'(interval_q)),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign status_o.speed_needed = live_q && (interval_q != '0) && (dir_q != qps_pkg::STEP_NONE);
  assign status_o.div_busy     = div_busy;
  assign status_o.div_done     = div_done;

endmodule

@@ hw/rtl/qps_ctrl.sv @@
// Controller: sequences accept, state update, division and result load.
// Depends on qps_pkg and the assertion macro header.
`include "quadrature_position_speed_unit_macros.svh"

module qps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qps_pkg::dp_cmd_t    dp_cmd_o,
  input  qps_pkg::dp_status_t dp_status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_accept, slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  assign dp_cmd_o.load_item   = in_accept;
  assign dp_cmd_o.update      = (state_q == ST_UPDATE);
  assign dp_cmd_o.div_start   = (state_q == ST_START) && dp_status_i.speed_needed;
  assign dp_cmd_o.clear_speed = (state_q == ST_START) && !dp_status_i.speed_needed;
  assign dp_cmd_o.load_out    = (state_q == ST_FINISH) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (dp_cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) state_q <= ST_UPDATE;
        end
        ST_UPDATE: state_q <= ST_START;
        ST_START: begin
          state_q <= dp_status_i.speed_needed ? ST_DIV : ST_FINISH;
        end
        ST_DIV: begin
          if (dp_status_i.div_done) state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (slot_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `QPSU_ASSERT(a_accept_blocks, in_accept |=> !in_ready_o, "accepted while busy")
  `QPSU_NEVER(a_start_while_busy, dp_cmd_o.div_start && dp_status_i.div_busy, "divider restarted")
  `QPSU_ASSERT(a_done_in_div, dp_status_i.div_done |-> state_q == ST_DIV, "stray divide done")
  `QPSU_ASSERT(a_load_slot_free, dp_cmd_o.load_out |=> out_valid_q, "result not presented")

endmodule

@@ hw/rtl/quadrature_position_speed_unit.sv @@
// Quadrature decoder with position count and period-based speed; top level.
// Each request passes accept, state update, divider start or speed clear, division if needed, then result load.
// Handles one request at a time; the 32-step divider runs only when a speed is needed.
// Next request is accepted in the cycle after the result is loaded, even if it is not yet taken.
// Reset: count, previous pins, last edge time, interval, speed zero; speed timeout 100000; no clearing pass.
module quadrature_position_speed_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  qps_in_if.sink    in_i,
  qps_out_if.source out_o,
  qps_cfg_if.sink   cfg_i
);

  qps_pkg::dp_cmd_t    dp_cmd;
  qps_pkg::dp_status_t dp_status;

  assign cfg_i.ready = 1'b1;

  qps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .dp_cmd_o    (dp_cmd),
    .dp_status_i (dp_status)
  );

  qps_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .in_cmd_i        (in_i.cmd),
    .in_level_a_i    (in_i.level_a),
    .in_level_b_i    (in_i.level_b),
    .in_now_time_i   (in_i.now_time),
    .cfg_write_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .position_o      (out_o.position),
    .direction_o     (out_o.direction),
    .edge_interval_o (out_o.edge_interval),
    .speed_o         (out_o.speed)
  );

endmodule
